// ----- rtl/cfr_pkg.sv -----
// shared constants, codes and types of the command frame receiver
`timescale 1ns / 1ps
package cfr_pkg;

  // parameter defaults
  localparam int MAX_PAYLOAD_BYTES_DEF = 16;
  localparam int NUM_COMMANDS_DEF      = 16;

  // fixed field widths
  localparam int IDX_W  = 4;
  localparam int LEN_W  = 5;
  localparam int TMR_W  = 16;
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_BADSUM  = 3'd2;
  localparam logic [2:0] ST_OTHER   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // source of command_number on a single result
  localparam logic [1:0] SEL_CURRENT = 2'd0;
  localparam logic [1:0] SEL_BYTE    = 2'd1;
  localparam logic [1:0] SEL_ZERO    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_DEVICE_ADDRESS = 3'd0;
  localparam logic [2:0] REG_VALID_MASK     = 3'd1;
  localparam logic [2:0] REG_LENGTHS_LOW    = 3'd2;
  localparam logic [2:0] REG_LENGTHS_HIGH   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd4;

  // register reset values
  localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd0;
  localparam logic [15:0] RST_VALID_MASK     = 16'd1023;
  localparam logic [63:0] RST_LENGTHS        = 64'd0;
  localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd1000;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] command_valid_mask;
    logic [63:0] command_lengths_low;
    logic [63:0] command_lengths_high;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       reload_timer;
    logic       dec_timer;
    logic       clear_timer;
    logic       latch_addr;
    logic       latch_cmd;
    logic       take_data;
    logic       load_single;
    logic [2:0] status;
    logic [1:0] cmd_sel;
    logic       start_run;
    logic       load_run;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic unknown;
    logic cmd_len_zero;  // length looked up for the incoming command byte
    logic len_zero;      // length latched for the current frame
    logic data_done;
    logic sum_ok;
    logic addressed;
    logic time_up;
    logic run_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/cfr_if.sv -----
// stream interfaces for received items and result transactions
`timescale 1ns / 1ps
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] command_number;
  logic [7:0] payload_byte;
  logic [3:0] payload_index;
  logic       has_payload;
  logic       last_of_run;

  modport source (output valid, output status, output command_number, output payload_byte,
                  output payload_index, output has_payload, output last_of_run,
                  input ready);
  modport sink   (input valid, input status, input command_number, input payload_byte,
                  input payload_index, input has_payload, input last_of_run,
                  output ready);
endinterface

// ----- rtl/command_frame_receiver.sv -----
// top level of the command frame receiver
// latency: an item is taken only while the result register is free; a result it causes is
//   registered and shown on the next cycle
// throughput: one item per cycle while the result register is free, except that
//   a good addressed frame with payload holds the input after its checksum byte
//   while the store is read out one entry per cycle into the free result register
// reset: synchronous, clears the phase, frame registers and configuration;
//   the payload store is not cleared
`timescale 1ns / 1ps
module command_frame_receiver #(
  parameter int MAX_PAYLOAD_BYTES = cfr_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int NUM_COMMANDS      = cfr_pkg::NUM_COMMANDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  cfr_in_if.sink                     frame,
  cfr_out_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfr_pkg::APB_AW-1:0] paddr,
  input  logic [cfr_pkg::APB_DW-1:0] pwdata,
  output logic [cfr_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  cfr_pkg::cfg_t     cfg;
  cfr_pkg::dp_cmd_t  cmd;
  cfr_pkg::dp_stat_t stat;

  // configuration registers, 64-bit apb at 8-byte stride
  cfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // phase machine, owns the input handshake
  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .opcode   (frame.opcode),
    .in_ready (frame.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // checksum, counts, timeout, payload store and the result register
  cfr_dp #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
    .NUM_COMMANDS      (NUM_COMMANDS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .rx_byte (frame.rx_byte),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  // an item is only taken when its result has a free slot
  assert property (@(posedge clk) disable iff (rst)
    frame.ready |-> (!result.valid || result.ready))
    else $error("input taken while result register is blocked");

  // payload results belong to accepted frames only
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.has_payload |-> result.status == cfr_pkg::ST_OK)
    else $error("payload result with non-accepted status");

  // every report without payload ends its run
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.has_payload |-> result.last_of_run)
    else $error("single report not marked last");

  // no input taken while a payload run is being emitted
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_run |-> !frame.ready)
    else $error("input accepted during payload run");

endmodule

// ----- rtl/cfr_regs.sv -----
// apb configuration register file
`timescale 1ns / 1ps
module cfr_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfr_pkg::APB_AW-1:0] paddr,
  input  logic [cfr_pkg::APB_DW-1:0] pwdata,
  output logic [cfr_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output cfr_pkg::cfg_t              cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address       <= cfr_pkg::RST_DEVICE_ADDRESS;
      cfg.command_valid_mask   <= cfr_pkg::RST_VALID_MASK;
      cfg.command_lengths_low  <= cfr_pkg::RST_LENGTHS;
      cfg.command_lengths_high <= cfr_pkg::RST_LENGTHS;
      cfg.timeout_ticks        <= cfr_pkg::RST_TIMEOUT_TICKS;
    end else if (wr) begin
      case (index)
        cfr_pkg::REG_DEVICE_ADDRESS: cfg.device_address       <= pwdata[7:0];
        cfr_pkg::REG_VALID_MASK:     cfg.command_valid_mask   <= pwdata[15:0];
        cfr_pkg::REG_LENGTHS_LOW:    cfg.command_lengths_low  <= pwdata;
        cfr_pkg::REG_LENGTHS_HIGH:   cfg.command_lengths_high <= pwdata;
        cfr_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      cfr_pkg::REG_DEVICE_ADDRESS: prdata = {56'd0, cfg.device_address};
      cfr_pkg::REG_VALID_MASK:     prdata = {48'd0, cfg.command_valid_mask};
      cfr_pkg::REG_LENGTHS_LOW:    prdata = cfg.command_lengths_low;
      cfr_pkg::REG_LENGTHS_HIGH:   prdata = cfg.command_lengths_high;
      cfr_pkg::REG_TIMEOUT_TICKS:  prdata = {48'd0, cfg.timeout_ticks};
      default:                     prdata = '0;
    endcase
  end

endmodule

// ----- rtl/cfr_dp.sv -----
// datapath: frame registers, payload store, timeout counter and result register
`timescale 1ns / 1ps
module cfr_dp #(
  parameter int MAX_PAYLOAD_BYTES = cfr_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int NUM_COMMANDS      = cfr_pkg::NUM_COMMANDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cfr_pkg::cfg_t       cfg,
  input  logic [7:0]          rx_byte,
  input  cfr_pkg::dp_cmd_t    cmd,
  output cfr_pkg::dp_stat_t   stat,
  cfr_out_if.source           result
);

  localparam int CAP  = (MAX_PAYLOAD_BYTES < 16) ? MAX_PAYLOAD_BYTES : 16;
  localparam int IDXW = (CAP > 1) ? $clog2(CAP) : 1;

  logic                      addressed;
  logic [3:0]                current_command;
  logic [cfr_pkg::LEN_W-1:0] expected_length;
  logic [cfr_pkg::LEN_W-1:0] received_count;
  logic [7:0]                running_checksum;
  logic [cfr_pkg::TMR_W-1:0] timeout_counter;
  logic [cfr_pkg::IDX_W-1:0] emit_idx;
  logic [7:0]                store [CAP];

  logic [7:0]                byte_len;
  logic [cfr_pkg::LEN_W-1:0] sat_len;
  logic [7:0]                single_cmd;

  // length lookup for the incoming command byte
  always_comb begin
    if (rx_byte[3]) begin
      byte_len = cfg.command_lengths_high[{rx_byte[2:0], 3'b000} +: 8];
    end else begin
      byte_len = cfg.command_lengths_low[{rx_byte[2:0], 3'b000} +: 8];
    end
    if (byte_len > 8'(CAP)) begin
      sat_len = cfr_pkg::LEN_W'(CAP);
    end else begin
      sat_len = byte_len[cfr_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    case (cmd.cmd_sel)
      cfr_pkg::SEL_BYTE: single_cmd = rx_byte;
      cfr_pkg::SEL_ZERO: single_cmd = 8'd0;
      default:           single_cmd = {4'd0, current_command};
    endcase
  end

  assign stat.unknown      = (rx_byte >= 8'(NUM_COMMANDS)) ||
                             !cfg.command_valid_mask[rx_byte[3:0]];
  assign stat.cmd_len_zero = sat_len == '0;
  assign stat.len_zero     = expected_length == '0;
  assign stat.data_done    = (received_count + 5'd1) >= expected_length;
  assign stat.sum_ok       = running_checksum == rx_byte;
  assign stat.addressed    = addressed;
  assign stat.time_up      = timeout_counter <= 16'd1;
  assign stat.run_last     = ({1'b0, emit_idx} + 5'd1) == expected_length;
  assign stat.out_free     = !result.valid || result.ready;

  // frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      addressed        <= 1'b0;
      current_command  <= '0;
      expected_length  <= '0;
      received_count   <= '0;
      running_checksum <= '0;
      timeout_counter  <= '0;
      emit_idx         <= '0;
    end else begin
      if (cmd.latch_addr) begin
        addressed <= rx_byte == cfg.device_address;
      end
      if (cmd.latch_cmd) begin
        current_command  <= rx_byte[3:0];
        expected_length  <= sat_len;
        received_count   <= '0;
        running_checksum <= rx_byte;
      end
      if (cmd.take_data) begin
        running_checksum <= running_checksum ^ rx_byte;
        received_count   <= received_count + 5'd1;
      end
      if (cmd.reload_timer) begin
        timeout_counter <= cfg.timeout_ticks;
      end else if (cmd.clear_timer) begin
        timeout_counter <= '0;
      end else if (cmd.dec_timer) begin
        timeout_counter <= timeout_counter - 16'd1;
      end
      if (cmd.start_run) begin
        emit_idx <= '0;
      end else if (cmd.load_run) begin
        emit_idx <= emit_idx + 4'd1;
      end
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      store[received_count[IDXW-1:0]] <= rx_byte;
    end
  end

  // result register, store read lands here
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_run) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      result.status         <= cmd.status;
      result.command_number <= single_cmd;
      result.payload_byte   <= 8'd0;
      result.payload_index  <= '0;
      result.has_payload    <= 1'b0;
      result.last_of_run    <= 1'b1;
    end else if (cmd.load_run) begin
      result.status         <= cfr_pkg::ST_OK;
      result.command_number <= {4'd0, current_command};
      result.payload_byte   <= store[emit_idx[IDXW-1:0]];
      result.payload_index  <= emit_idx;
      result.has_payload    <= 1'b1;
      result.last_of_run    <= stat.run_last;
    end
  end

endmodule

// ----- rtl/cfr_ctrl.sv -----
// controller state machine: frame phases and payload run sequencing
`timescale 1ns / 1ps
module cfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              opcode,
  output logic              in_ready,
  input  cfr_pkg::dp_stat_t stat,
  output cfr_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_DATA = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state != S_EMIT) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.status = cfr_pkg::ST_OK;
    cmd.cmd_sel = cfr_pkg::SEL_CURRENT;
    if (state == S_EMIT) begin
      if (stat.out_free) begin
        cmd.load_run = 1'b1;
        if (stat.run_last) begin
          state_next = S_IDLE;
        end
      end
    end else if (accept && opcode) begin
      // timer tick, ignored while idle
      if (state != S_IDLE) begin
        if (stat.time_up) begin
          cmd.load_single = 1'b1;
          cmd.status      = cfr_pkg::ST_TIMEOUT;
          cmd.cmd_sel     = (state == S_CMD) ? cfr_pkg::SEL_ZERO : cfr_pkg::SEL_CURRENT;
          cmd.clear_timer = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.dec_timer = 1'b1;
        end
      end
    end else if (accept) begin
      cmd.reload_timer = 1'b1;
      case (state)
        S_IDLE: begin
          cmd.latch_addr = 1'b1;
          state_next     = S_CMD;
        end
        S_CMD: begin
          if (stat.unknown) begin
            cmd.load_single = 1'b1;
            cmd.status      = cfr_pkg::ST_UNKNOWN;
            cmd.cmd_sel     = cfr_pkg::SEL_BYTE;
            state_next      = S_IDLE;
          end else begin
            cmd.latch_cmd = 1'b1;
            state_next    = stat.cmd_len_zero ? S_CHK : S_DATA;
          end
        end
        S_DATA: begin
          cmd.take_data = 1'b1;
          if (stat.data_done) begin
            state_next = S_CHK;
          end
        end
        S_CHK: begin
          state_next = S_IDLE;
          if (!stat.sum_ok) begin
            cmd.load_single = 1'b1;
            cmd.status      = cfr_pkg::ST_BADSUM;
          end else if (!stat.addressed) begin
            cmd.load_single = 1'b1;
            cmd.status      = cfr_pkg::ST_OTHER;
          end else if (stat.len_zero) begin
            cmd.load_single = 1'b1;
            cmd.status      = cfr_pkg::ST_OK;
          end else begin
            cmd.start_run = 1'b1;
            state_next    = S_EMIT;
          end
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- tb/tb.sv -----
// self-checking testbench of the command frame receiver
`timescale 1ns / 1ps

// one result transaction as seen on the result channel
typedef struct packed {
  logic [2:0] status;
  logic [7:0] command_number;
  logic [7:0] payload_byte;
  logic [3:0] payload_index;
  logic       has_payload;
  logic       last_of_run;
} frame_report_t;

// where the receiver stands within a frame
typedef enum logic [1:0] {
  WAIT_ADDR,
  WAIT_CMD,
  WAIT_DATA,
  WAIT_SUM
} rx_phase_e;

// input item kinds
localparam logic OP_BYTE = 1'b0;
localparam logic OP_TICK = 1'b1;

// register index past the end of the map, must be ignored
localparam logic [2:0] REG_SPARE = 3'd5;

// payload store depth and command count of the default build
localparam int PAYLOAD_CAP  = (cfr_pkg::MAX_PAYLOAD_BYTES_DEF < 16) ?
                              cfr_pkg::MAX_PAYLOAD_BYTES_DEF : 16;
localparam int NUM_COMMANDS = cfr_pkg::NUM_COMMANDS_DEF;

// keeps its own copy of the frame parser and the reports it must produce
class frame_scoreboard;
  logic [7:0]      dev_addr;
  logic [15:0]     valid_mask;
  logic [63:0]     len_lo;
  logic [63:0]     len_hi;
  logic [15:0]     tmo_ticks;

  rx_phase_e       phase;
  bit              addressed;
  logic [3:0]      cur_cmd;
  int              exp_len;
  int              rx_count;
  logic [7:0]      run_sum;
  logic [15:0]     tmo_count;
  logic [7:0]      store [16];

  frame_report_t   expected_reports [$];
  int              failures;

  function new();
    dev_addr   = cfr_pkg::RST_DEVICE_ADDRESS;
    valid_mask = cfr_pkg::RST_VALID_MASK;
    len_lo     = cfr_pkg::RST_LENGTHS;
    len_hi     = cfr_pkg::RST_LENGTHS;
    tmo_ticks  = cfr_pkg::RST_TIMEOUT_TICKS;
    phase      = WAIT_ADDR;
    addressed  = 0;
    cur_cmd    = '0;
    exp_len    = 0;
    rx_count   = 0;
    run_sum    = '0;
    tmo_count  = '0;
    failures   = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      cfr_pkg::REG_DEVICE_ADDRESS: dev_addr   = val[7:0];
      cfr_pkg::REG_VALID_MASK:     valid_mask = val[15:0];
      cfr_pkg::REG_LENGTHS_LOW:    len_lo     = val;
      cfr_pkg::REG_LENGTHS_HIGH:   len_hi     = val;
      cfr_pkg::REG_TIMEOUT_TICKS:  tmo_ticks  = val[15:0];
      default: ;
    endcase
  endfunction

  function bit command_known(logic [7:0] cmd);
    return (cmd < NUM_COMMANDS) && valid_mask[cmd[3:0]];
  endfunction

  // configured payload length, saturated to the store depth
  function int payload_len(logic [3:0] cmd);
    logic [63:0] table_word;
    logic [7:0]  len_byte;
    table_word = cmd[3] ? len_hi : len_lo;
    len_byte   = table_word[cmd[2:0]*8 +: 8];
    return (len_byte > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(len_byte);
  endfunction

  function void add_report(logic [2:0] st, logic [7:0] cmd, logic [7:0] pbyte,
                           logic [3:0] pidx, logic has, logic last);
    frame_report_t r;
    r.status         = st;
    r.command_number = cmd;
    r.payload_byte   = pbyte;
    r.payload_index  = pidx;
    r.has_payload    = has;
    r.last_of_run    = last;
    expected_reports.push_back(r);
  endfunction

  // returns 0 for an item the receiver just ignores
  function bit note_item(logic op, logic [7:0] b);
    if (op == OP_TICK) begin
      if (phase == WAIT_ADDR) return 0;
      if (tmo_count <= 1) begin
        add_report(cfr_pkg::ST_TIMEOUT, (phase == WAIT_CMD) ? 8'd0 : {4'd0, cur_cmd},
                   8'd0, 4'd0, 1'b0, 1'b1);
        tmo_count = '0;
        phase     = WAIT_ADDR;
        addressed = 0;
      end else begin
        tmo_count--;
      end
      return 1;
    end
    tmo_count = tmo_ticks;
    case (phase)
      WAIT_ADDR: begin
        addressed = (b == dev_addr);
        phase     = WAIT_CMD;
      end
      WAIT_CMD: begin
        if (!command_known(b)) begin
          add_report(cfr_pkg::ST_UNKNOWN, b, 8'd0, 4'd0, 1'b0, 1'b1);
          phase     = WAIT_ADDR;
          addressed = 0;
        end else begin
          cur_cmd  = b[3:0];
          exp_len  = payload_len(b[3:0]);
          rx_count = 0;
          run_sum  = b;
          phase    = (exp_len > 0) ? WAIT_DATA : WAIT_SUM;
        end
      end
      WAIT_DATA: begin
        store[rx_count[3:0]] = b;
        run_sum  = run_sum ^ b;
        rx_count = rx_count + 1;
        if (rx_count >= exp_len) phase = WAIT_SUM;
      end
      default: begin
        if (run_sum != b)
          add_report(cfr_pkg::ST_BADSUM, {4'd0, cur_cmd}, 8'd0, 4'd0, 1'b0, 1'b1);
        else if (!addressed)
          add_report(cfr_pkg::ST_OTHER, {4'd0, cur_cmd}, 8'd0, 4'd0, 1'b0, 1'b1);
        else if (exp_len == 0)
          add_report(cfr_pkg::ST_OK, {4'd0, cur_cmd}, 8'd0, 4'd0, 1'b0, 1'b1);
        else
          for (int i = 0; i < exp_len; i++)
            add_report(cfr_pkg::ST_OK, {4'd0, cur_cmd}, store[i], i[3:0], 1'b1,
                       i + 1 == exp_len);
        phase     = WAIT_ADDR;
        addressed = 0;
      end
    endcase
    return 1;
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  function void check_report(frame_report_t got);
    frame_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t unexpected result expected none actual status %0d cmd %0d",
               $time, got.status, got.command_number);
      failures++;
      return;
    end
    want = expected_reports.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("command_number", want.command_number, got.command_number);
    compare_field("payload_byte", want.payload_byte, got.payload_byte);
    compare_field("payload_index", want.payload_index, got.payload_index);
    compare_field("has_payload", want.has_payload, got.has_payload);
    compare_field("last_of_run", want.last_of_run, got.last_of_run);
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction
endclass

module tb;
  // cycles with no transaction on either channel before the run is abandoned
  localparam int STALL_LIMIT      = 1000;
  // length of the one long result back-pressure stretch
  localparam int LONG_HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [cfr_pkg::APB_AW-1:0] paddr;
  logic [cfr_pkg::APB_DW-1:0] pwdata;
  logic [cfr_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  cfr_in_if  frame_if ();
  cfr_out_if result_if ();

  frame_scoreboard sb;
  int  items_sent;
  int  quiet_cycles;
  bit  quiet_tail;    // no idling on either side in the closing phase
  bit  hold_request;  // asks the result side for one long hold-off

  command_frame_receiver dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random ready bursts, one long hold on request
  initial begin : result_sink
    result_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        result_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        result_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        sb.check_report('{status:         result_if.status,
                          command_number: result_if.command_number,
                          payload_byte:   result_if.payload_byte,
                          payload_index:  result_if.payload_index,
                          has_payload:    result_if.has_payload,
                          last_of_run:    result_if.last_of_run});
      end
      if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL command_frame_receiver");
        $finish;
      end
    end
  end

  // one byte or tick transaction, with an occasional idle burst in front
  task automatic send_item(input logic op, input logic [7:0] b);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      frame_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    frame_if.valid   <= 1'b1;
    frame_if.opcode  <= op;
    frame_if.rx_byte <= b;
    do @(posedge clk); while (!frame_if.ready);
    if (sb.note_item(op, b)) items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  // stop sending, let every expected result come out, then let the
  // receiver settle
  task automatic drain();
    frame_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb setup and access cycle; psel stays up for a following write
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
  endtask

  // full register set, written only with the receiver quiet
  task automatic configure(input logic [7:0] dev, input logic [15:0] mask,
                           input logic [63:0] lo, input logic [63:0] hi,
                           input logic [15:0] ticks);
    drain();
    reg_write(cfr_pkg::REG_DEVICE_ADDRESS, {56'd0, dev});
    reg_write(cfr_pkg::REG_VALID_MASK, {48'd0, mask});
    reg_write(cfr_pkg::REG_LENGTHS_LOW, lo);
    reg_write(cfr_pkg::REG_LENGTHS_HIGH, hi);
    reg_write(cfr_pkg::REG_TIMEOUT_TICKS, {48'd0, ticks});
    reg_write(REG_SPARE, {$urandom, $urandom});
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // length table: mostly short payloads, now and then an overlong one
  function automatic logic [63:0] length_table(input int top);
    logic [63:0] t;
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 9) == 0)
        t[i*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'd17;
      else
        t[i*8 +: 8] = 8'($urandom_range(0, top));
    end
    return t;
  endfunction

  // timer ticks now and then between bytes
  task automatic maybe_ticks();
    if ($urandom_range(0, 11) == 0)
      repeat ($urandom_range(1, 3)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // mostly well-formed frames with random content; the rest is noise,
  // truncated frames and corrupted checksums
  task automatic random_frame();
    int         roll;
    int         len;
    int         stop_at;
    logic [7:0] cmd;
    logic [7:0] sum;
    logic [7:0] b;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 4))
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      return;
    end
    send_byte((roll < 75) ? sb.dev_addr : 8'($urandom_range(0, 255)));
    maybe_ticks();
    cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                        8'($urandom_range(0, NUM_COMMANDS - 1));
    send_byte(cmd);
    if (!sb.command_known(cmd)) return;
    len     = sb.payload_len(cmd[3:0]);
    stop_at = (roll < 13) ? $urandom_range(0, len) : len + 1;
    sum     = cmd;
    for (int i = 0; i < len; i++) begin
      if (i == stop_at) return;
      maybe_ticks();
      b   = 8'($urandom_range(0, 255));
      sum = sum ^ b;
      send_byte(b);
    end
    if (stop_at == len) return;
    maybe_ticks();
    if ($urandom_range(0, 99) < 15) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic run_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) random_frame();
  endtask

  initial begin : stimulus
    sb              = new();
    items_sent      = 0;
    quiet_tail      = 0;
    hold_request    = 0;
    rst             = 1'b1;
    frame_if.valid   = 1'b0;
    frame_if.opcode  = OP_BYTE;
    frame_if.rx_byte = 8'd0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: command 0 without payload, 1 with one byte, 2 with two,
    // 8 and up undefined, two-tick timeout
    configure(8'hA5, 16'h00FF, 64'h0000_0000_0002_0100, 64'd0, 16'd2);
    send_item(OP_TICK, 8'hFF);                       // tick while idle
    send_byte(8'hA5); send_byte(8'h00); send_byte(8'h00);   // accepted, no payload
    send_byte(8'hA5); send_byte(8'h02);               // accepted with a payload run
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFD);
    send_byte(8'h00); send_byte(8'hFF);               // command byte out of range
    send_byte(8'hA5); send_byte(8'h09);               // command masked off
    send_byte(8'hA5); send_byte(8'h01);               // checksum bad
    send_byte(8'h3C); send_byte(8'h00);
    send_byte(8'h5A); send_byte(8'h00); send_byte(8'h00);   // good frame, other device
    send_byte(8'hA5); send_item(OP_TICK, 8'h00);      // timeout before the command
    send_item(OP_TICK, 8'h00);
    send_byte(8'hA5); send_byte(8'h01);               // timeout with a command
    send_item(OP_TICK, 8'h00); send_item(OP_TICK, 8'hFF);

    // lowest device address, every command defined, one-tick timeout
    configure(8'h00, 16'hFFFF, length_table(4), length_table(4), 16'd1);
    run_random(60);

    // back-pressure: result side holds off while frames keep coming,
    // then the sender waits for every result before going on
    configure(8'hFF, 16'hFFFF, length_table(10), length_table(10), 16'hFFFF);
    hold_request = 1;
    run_random(30);
    drain();
    run_random(30);

    // no command defined at all
    configure(8'($urandom_range(0, 255)), 16'h0000, length_table(4), length_table(4),
              16'($urandom_range(1, 65535)));
    run_random(20);

    // random definitions, short timeouts so ticks often drop frames
    configure(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)) | 16'h0011,
              length_table(5), length_table(5), 16'($urandom_range(1, 6)));
    run_random(80);

    // every length overlong, saturating to the full store
    configure(8'($urandom_range(0, 255)), 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 16'($urandom_range(8, 200)));
    run_random(40);

    // closing phase at full rate on both sides
    configure(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)) | 16'h0101,
              length_table(4), length_table(4), 16'($urandom_range(2, 40)));
    quiet_tail = 1;
    run_random(60);

    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("PASS command_frame_receiver");
    else
      $display("FAIL command_frame_receiver");
    $finish;
  end
endmodule
